### design/sfsc_pkg.sv
// Package for the sex-specific Fst / SNP classifier: widths, register
// indexes, pipeline stage indexes and the per-stage metadata type.
// No dependencies.
package sfsc_pkg;

	localparam int COUNT_WIDTH    = 16;
	localparam int FRAC_BITS      = 16;
	localparam int NUM_ALLELES    = 5;
	localparam int LANES          = 2 * NUM_ALLELES;
	localparam int POS_WIDTH      = 32;
	localparam int WIN_WIDTH      = 16;
	localparam int TOT_WIDTH      = COUNT_WIDTH + 3;          // sum of five counts
	localparam int PROB_WIDTH     = FRAC_BITS + 1;            // frequency, up to 1.0
	localparam int FST_WIDTH      = FRAC_BITS + 2;
	localparam int PSQ_WIDTH      = 2 * PROB_WIDTH;
	localparam int SSQ_WIDTH      = 2 * (PROB_WIDTH + 1);
	localparam int HET_WIDTH      = 2 * FRAC_BITS + 3;        // holds 4.0 at 2F scale
	localparam int ADJ_WIDTH      = HET_WIDTH + 1;
	localparam int NH_WIDTH       = TOT_WIDTH + WIN_WIDTH;
	localparam int NT_WIDTH       = TOT_WIDTH + 4;
	localparam int CFG_ADDR_WIDTH = 4;
	localparam int CFG_DATA_WIDTH = 32;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MIN_READS  = 2'd0;
	localparam logic [1:0] REG_SNP_WINDOW = 2'd1;
	localparam logic [1:0] REG_MIN_FST    = 2'd2;

	localparam logic [COUNT_WIDTH-1:0]      MIN_READS_RST  = COUNT_WIDTH'(10);
	localparam logic [WIN_WIDTH-1:0]        SNP_WINDOW_RST = WIN_WIDTH'(6554);
	localparam logic signed [FST_WIDTH-1:0] MIN_FST_RST    = FST_WIDTH'(6554);

	localparam logic [HET_WIDTH-1:0]  ONE_SQ  = HET_WIDTH'(1) << (2 * FRAC_BITS);
	localparam logic [HET_WIDTH-1:0]  FOUR_SQ = HET_WIDTH'(1) << (2 * FRAC_BITS + 2);
	localparam logic [PROB_WIDTH-1:0] P_ONE   = PROB_WIDTH'(1) << FRAC_BITS;

	// pipeline stage indexes (metadata array positions)
	localparam int DIV2_STEPS = HET_WIDTH;
	localparam int IDX_D1     = 1;
	localparam int IDX_SQ     = IDX_D1 + FRAC_BITS + 1;
	localparam int IDX_D2     = IDX_SQ + 1;
	localparam int IDX_AD     = IDX_D2 + DIV2_STEPS + 1;
	localparam int IDX_D3     = IDX_AD + 1;
	localparam int IDX_FN     = IDX_D3 + FRAC_BITS + 1;
	localparam int PIPE_DEPTH = IDX_FN + 1;

	typedef struct packed {
		logic [POS_WIDTH-1:0] position;
		logic                 gate;
		logic                 snp_m;
		logic                 snp_f;
	} meta_t;

endpackage

### design/sex_fst_snp_classifier.sv
// The done strobe marks each result; one new position can be accepted
// every cycle, busy is held low.
// Most of the pipeline is the three restoring dividers, one quotient bit per stage.
// Reset clears all pipeline valid bits and loads the register defaults.
// Depends on sfsc_pkg.
module sex_fst_snp_classifier import sfsc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_ADDR_WIDTH-1:0]     paddr,
	input  logic [CFG_DATA_WIDTH-1:0]     pwdata,
	output logic [CFG_DATA_WIDTH-1:0]     prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [POS_WIDTH-1:0]          position,
	input  logic [COUNT_WIDTH-1:0]        male_a,
	input  logic [COUNT_WIDTH-1:0]        male_t,
	input  logic [COUNT_WIDTH-1:0]        male_g,
	input  logic [COUNT_WIDTH-1:0]        male_c,
	input  logic [COUNT_WIDTH-1:0]        male_indel,
	input  logic [COUNT_WIDTH-1:0]        female_a,
	input  logic [COUNT_WIDTH-1:0]        female_t,
	input  logic [COUNT_WIDTH-1:0]        female_g,
	input  logic [COUNT_WIDTH-1:0]        female_c,
	input  logic [COUNT_WIDTH-1:0]        female_indel,
	output logic                          done,
	output logic [POS_WIDTH-1:0]          out_position,
	output logic signed [FST_WIDTH-1:0]   fst_value,
	output logic                          fst_report,
	output logic [1:0]                    snp_class
);

	function automatic logic [TOT_WIDTH:0] long_step(input logic [TOT_WIDTH-1:0] rem,
			input logic inbit, input logic [TOT_WIDTH-1:0] dvs);
		logic [TOT_WIDTH:0] t;
		logic [TOT_WIDTH:0] d;
		t = {rem, inbit};
		d = t - {1'b0, dvs};
		if (t >= {1'b0, dvs}) begin
			return {1'b1, d[TOT_WIDTH-1:0]};
		end
		return {1'b0, t[TOT_WIDTH-1:0]};
	endfunction

	function automatic logic [ADJ_WIDTH:0] wide_step(input logic [ADJ_WIDTH-1:0] rem,
			input logic [ADJ_WIDTH-1:0] dvs);
		logic [ADJ_WIDTH:0] t;
		logic [ADJ_WIDTH:0] d;
		t = {rem, 1'b0};
		d = t - {1'b0, dvs};
		if (t >= {1'b0, dvs}) begin
			return {1'b1, d[ADJ_WIDTH-1:0]};
		end
		return {1'b0, t[ADJ_WIDTH-1:0]};
	endfunction

	function automatic logic near_half(input logic [COUNT_WIDTH-1:0] c,
			input logic [TOT_WIDTH-1:0] tot, input logic [WIN_WIDTH-1:0] win);
		logic [TOT_WIDTH:0] twice;
		logic [TOT_WIDTH:0] tot_x;
		logic [TOT_WIDTH:0] d;
		logic [NH_WIDTH-1:0] lhs;
		logic [NH_WIDTH-1:0] rhs;
		twice = {(TOT_WIDTH-COUNT_WIDTH)'(0), c, 1'b0};
		tot_x = {1'b0, tot};
		d = (twice >= tot_x) ? twice - tot_x : tot_x - twice;
		lhs = NH_WIDTH'({d, 15'b0});
		rhs = NH_WIDTH'(win) * NH_WIDTH'(tot);
		return lhs < rhs;
	endfunction

	function automatic logic above_nine(input logic [COUNT_WIDTH-1:0] c,
			input logic [TOT_WIDTH-1:0] tot);
		return (NT_WIDTH'(c) * NT_WIDTH'(10)) > (NT_WIDTH'(tot) * NT_WIDTH'(9));
	endfunction

	// configuration registers
	logic [COUNT_WIDTH-1:0]      min_reads_q;
	logic [WIN_WIDTH-1:0]        snp_window_q;
	logic signed [FST_WIDTH-1:0] min_fst_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_reads_q  <= MIN_READS_RST;
			snp_window_q <= SNP_WINDOW_RST;
			min_fst_q    <= MIN_FST_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MIN_READS:  min_reads_q  <= pwdata[COUNT_WIDTH-1:0];
				REG_SNP_WINDOW: snp_window_q <= pwdata[WIN_WIDTH-1:0];
				REG_MIN_FST:    min_fst_q    <= pwdata[FST_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MIN_READS:  prdata = CFG_DATA_WIDTH'(min_reads_q);
			REG_SNP_WINDOW: prdata = CFG_DATA_WIDTH'(snp_window_q);
			REG_MIN_FST:    prdata = {{(CFG_DATA_WIDTH-FST_WIDTH){min_fst_q[FST_WIDTH-1]}},
				min_fst_q};
			default:        prdata = '0;
		endcase
	end

	// metadata and valid pipeline
	meta_t meta_s [PIPE_DEPTH];
	logic  vld_s  [PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_DEPTH; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= start & ~busy;
			for (int k = 1; k < PIPE_DEPTH; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 1: totals and coverage gate
	logic [COUNT_WIDTH-1:0] cnt_in [LANES];
	logic [TOT_WIDTH-1:0]   tot_m, tot_f;
	logic [COUNT_WIDTH-1:0] cnt_s1 [LANES];
	logic [TOT_WIDTH-1:0]   mt_s1, ft_s1;

	assign cnt_in[0] = male_a;
	assign cnt_in[1] = male_t;
	assign cnt_in[2] = male_g;
	assign cnt_in[3] = male_c;
	assign cnt_in[4] = male_indel;
	assign cnt_in[5] = female_a;
	assign cnt_in[6] = female_t;
	assign cnt_in[7] = female_g;
	assign cnt_in[8] = female_c;
	assign cnt_in[9] = female_indel;

	always_comb begin
		tot_m = '0;
		tot_f = '0;
		for (int i = 0; i < NUM_ALLELES; i++) begin
			tot_m = tot_m + TOT_WIDTH'(cnt_in[i]);
			tot_f = tot_f + TOT_WIDTH'(cnt_in[i+NUM_ALLELES]);
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_in;
		mt_s1  <= tot_m;
		ft_s1  <= tot_f;
		meta_s[0].position <= position;
		meta_s[0].gate     <= (tot_m > TOT_WIDTH'(min_reads_q)) &&
			(tot_f > TOT_WIDTH'(min_reads_q)) &&
			(tot_m >= TOT_WIDTH'(2)) && (tot_f >= TOT_WIDTH'(2));
		meta_s[0].snp_m    <= 1'b0;
		meta_s[0].snp_f    <= 1'b0;
	end

	// stage 2: SNP tests, load frequency dividers
	logic snp_m_c, snp_f_c;

	always_comb begin
		snp_m_c = 1'b0;
		snp_f_c = 1'b0;
		for (int i = 0; i < NUM_ALLELES; i++) begin
			if (near_half(cnt_s1[i], mt_s1, snp_window_q) &&
					above_nine(cnt_s1[i+NUM_ALLELES], ft_s1)) begin
				snp_m_c = 1'b1;
			end
			if (near_half(cnt_s1[i+NUM_ALLELES], ft_s1, snp_window_q) &&
					above_nine(cnt_s1[i], mt_s1)) begin
				snp_f_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_s[IDX_D1]       <= meta_s[0];
		meta_s[IDX_D1].snp_m <= snp_m_c;
		meta_s[IDX_D1].snp_f <= snp_f_c;
	end

	for (genvar k = IDX_D1 + 1; k < PIPE_DEPTH; k++) begin : g_meta
		always_ff @(posedge clk) begin
			meta_s[k] <= meta_s[k-1];
		end
	end

	// frequency dividers: p = count * 2^F / total
	logic [TOT_WIDTH-1:0] d1_rem_s  [FRAC_BITS+1][LANES];
	logic [FRAC_BITS-1:0] d1_quo_s  [FRAC_BITS+1][LANES];
	logic                 d1_full_s [FRAC_BITS+1][LANES];
	logic [TOT_WIDTH-1:0] d1_mt_s   [FRAC_BITS+1];
	logic [TOT_WIDTH-1:0] d1_ft_s   [FRAC_BITS+1];

	always_ff @(posedge clk) begin
		d1_mt_s[0] <= mt_s1;
		d1_ft_s[0] <= ft_s1;
	end

	for (genvar l = 0; l < LANES; l++) begin : g_d1_load
		always_ff @(posedge clk) begin
			d1_rem_s[0][l]  <= TOT_WIDTH'(cnt_s1[l]);
			d1_quo_s[0][l]  <= '0;
			d1_full_s[0][l] <= TOT_WIDTH'(cnt_s1[l]) >=
				((l < NUM_ALLELES) ? mt_s1 : ft_s1);
		end
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_d1
		always_ff @(posedge clk) begin
			d1_mt_s[k] <= d1_mt_s[k-1];
			d1_ft_s[k] <= d1_ft_s[k-1];
		end
		for (genvar l = 0; l < LANES; l++) begin : g_ln
			logic [TOT_WIDTH:0] nxt;
			assign nxt = long_step(d1_rem_s[k-1][l], 1'b0,
				(l < NUM_ALLELES) ? d1_mt_s[k-1] : d1_ft_s[k-1]);
			always_ff @(posedge clk) begin
				d1_rem_s[k][l]  <= nxt[TOT_WIDTH-1:0];
				d1_quo_s[k][l]  <= {d1_quo_s[k-1][l][FRAC_BITS-2:0], nxt[TOT_WIDTH]};
				d1_full_s[k][l] <= d1_full_s[k-1][l];
			end
		end
	end

	// squares of group and combined frequencies
	logic [PROB_WIDTH-1:0] prob [LANES];
	logic [PSQ_WIDTH-1:0]  psq_s19 [LANES];
	logic [SSQ_WIDTH-1:0]  ssq_s19 [NUM_ALLELES];
	logic [TOT_WIDTH-1:0]  mt_s19, ft_s19;

	for (genvar l = 0; l < LANES; l++) begin : g_prob
		assign prob[l] = d1_full_s[FRAC_BITS][l] ? P_ONE :
			{1'b0, d1_quo_s[FRAC_BITS][l]};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			psq_s19[l] <= PSQ_WIDTH'(prob[l]) * PSQ_WIDTH'(prob[l]);
		end
		for (int i = 0; i < NUM_ALLELES; i++) begin
			ssq_s19[i] <= (SSQ_WIDTH'(prob[i]) + SSQ_WIDTH'(prob[i+NUM_ALLELES])) *
				(SSQ_WIDTH'(prob[i]) + SSQ_WIDTH'(prob[i+NUM_ALLELES]));
		end
		mt_s19 <= d1_mt_s[FRAC_BITS];
		ft_s19 <= d1_ft_s[FRAC_BITS];
	end

	// heterozygosities, then divide by n-1 (lanes: male, female, total)
	logic [HET_WIDTH-1:0] sum_m, sum_f, sum_s;
	logic [TOT_WIDTH-1:0] n_min;
	logic [HET_WIDTH-1:0] d2_quo_s [DIV2_STEPS+1][3];
	logic [HET_WIDTH-1:0] d2_org_s [DIV2_STEPS+1][3];
	logic [TOT_WIDTH-1:0] d2_rem_s [DIV2_STEPS+1][3];
	logic [TOT_WIDTH-1:0] d2_dvs_s [DIV2_STEPS+1][3];

	always_comb begin
		sum_m = '0;
		sum_f = '0;
		sum_s = '0;
		for (int i = 0; i < NUM_ALLELES; i++) begin
			sum_m = sum_m + HET_WIDTH'(psq_s19[i]);
			sum_f = sum_f + HET_WIDTH'(psq_s19[i+NUM_ALLELES]);
			sum_s = sum_s + HET_WIDTH'(ssq_s19[i]);
		end
	end

	assign n_min = (mt_s19 < ft_s19) ? mt_s19 : ft_s19;

	always_ff @(posedge clk) begin
		d2_quo_s[0][0] <= ONE_SQ - sum_m;
		d2_quo_s[0][1] <= ONE_SQ - sum_f;
		d2_quo_s[0][2] <= FOUR_SQ - sum_s;
		d2_org_s[0][0] <= ONE_SQ - sum_m;
		d2_org_s[0][1] <= ONE_SQ - sum_f;
		d2_org_s[0][2] <= FOUR_SQ - sum_s;
		d2_dvs_s[0][0] <= mt_s19 - TOT_WIDTH'(1);
		d2_dvs_s[0][1] <= ft_s19 - TOT_WIDTH'(1);
		d2_dvs_s[0][2] <= n_min - TOT_WIDTH'(1);
		for (int j = 0; j < 3; j++) d2_rem_s[0][j] <= '0;
	end

	for (genvar k = 1; k <= DIV2_STEPS; k++) begin : g_d2
		for (genvar j = 0; j < 3; j++) begin : g_ln
			logic [TOT_WIDTH:0] nxt;
			assign nxt = long_step(d2_rem_s[k-1][j], d2_quo_s[k-1][j][HET_WIDTH-1],
				d2_dvs_s[k-1][j]);
			always_ff @(posedge clk) begin
				d2_rem_s[k][j] <= nxt[TOT_WIDTH-1:0];
				d2_quo_s[k][j] <= {d2_quo_s[k-1][j][HET_WIDTH-2:0], nxt[TOT_WIDTH]};
				d2_org_s[k][j] <= d2_org_s[k-1][j];
				d2_dvs_s[k][j] <= d2_dvs_s[k-1][j];
			end
		end
	end

	// corrected values, within-group diversity at total scale
	logic [ADJ_WIDTH-1:0] hsum;
	logic [ADJ_WIDTH-1:0] w_s56, ht_s56;

	assign hsum = ADJ_WIDTH'(d2_org_s[DIV2_STEPS][0]) + ADJ_WIDTH'(d2_quo_s[DIV2_STEPS][0]) +
		ADJ_WIDTH'(d2_org_s[DIV2_STEPS][1]) + ADJ_WIDTH'(d2_quo_s[DIV2_STEPS][1]);

	always_ff @(posedge clk) begin
		w_s56  <= {hsum[ADJ_WIDTH-2:0], 1'b0};
		ht_s56 <= ADJ_WIDTH'(d2_org_s[DIV2_STEPS][2]) + ADJ_WIDTH'(d2_quo_s[DIV2_STEPS][2]);
	end

	// Fst magnitude: |H - W| * 2^F / H
	logic [ADJ_WIDTH-1:0] d3_rem_s  [FRAC_BITS+1];
	logic [ADJ_WIDTH-1:0] d3_dvs_s  [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] d3_quo_s  [FRAC_BITS+1];
	logic                 d3_neg_s  [FRAC_BITS+1];
	logic                 d3_zero_s [FRAC_BITS+1];
	logic                 d3_full_s [FRAC_BITS+1];
	logic                 w_gt;
	logic [ADJ_WIDTH-1:0] diff;

	assign w_gt = w_s56 > ht_s56;
	assign diff = w_gt ? w_s56 - ht_s56 : ht_s56 - w_s56;

	always_ff @(posedge clk) begin
		d3_rem_s[0]  <= diff;
		d3_dvs_s[0]  <= ht_s56;
		d3_quo_s[0]  <= '0;
		d3_neg_s[0]  <= w_gt;
		d3_zero_s[0] <= ht_s56 == '0;
		d3_full_s[0] <= diff >= ht_s56;
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_d3
		logic [ADJ_WIDTH:0] nxt;
		assign nxt = wide_step(d3_rem_s[k-1], d3_dvs_s[k-1]);
		always_ff @(posedge clk) begin
			d3_rem_s[k]  <= nxt[ADJ_WIDTH-1:0];
			d3_quo_s[k]  <= {d3_quo_s[k-1][FRAC_BITS-2:0], nxt[ADJ_WIDTH]};
			d3_dvs_s[k]  <= d3_dvs_s[k-1];
			d3_neg_s[k]  <= d3_neg_s[k-1];
			d3_zero_s[k] <= d3_zero_s[k-1];
			d3_full_s[k] <= d3_full_s[k-1];
		end
	end

	// final: sign, gate, threshold compare
	logic [PROB_WIDTH-1:0]       mag;
	logic signed [FST_WIDTH-1:0] fst_c;
	meta_t                       meta_fn;
	logic [POS_WIDTH-1:0]        pos_s74;
	logic signed [FST_WIDTH-1:0] fst_s74;
	logic                        rep_s74;
	logic [1:0]                  cls_s74;

	assign meta_fn = meta_s[IDX_FN-1];
	assign mag = d3_full_s[FRAC_BITS] ? P_ONE : {1'b0, d3_quo_s[FRAC_BITS]};

	always_comb begin
		if (meta_fn.gate && !d3_zero_s[FRAC_BITS]) begin
			fst_c = d3_neg_s[FRAC_BITS] ? -$signed(FST_WIDTH'(mag)) : $signed(FST_WIDTH'(mag));
		end else begin
			fst_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		pos_s74 <= meta_fn.position;
		fst_s74 <= fst_c;
		rep_s74 <= fst_c >= min_fst_q;
		cls_s74 <= meta_fn.gate ? {meta_fn.snp_f, meta_fn.snp_m} : 2'b00;
	end

	assign done         = vld_s[IDX_FN];
	assign out_position = pos_s74;
	assign fst_value    = fst_s74;
	assign fst_report   = rep_s74;
	assign snp_class    = cls_s74;

endmodule

### design/sfsc_checker.sv
// Port-level checker for the Fst / SNP classifier, bound to the top level.
// Depends on sfsc_pkg and sex_fst_snp_classifier.
module sfsc_checker import sfsc_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [CFG_ADDR_WIDTH-1:0]   paddr,
	input logic [CFG_DATA_WIDTH-1:0]   pwdata,
	input logic [CFG_DATA_WIDTH-1:0]   prdata,
	input logic                        pready,
	input logic                        start,
	input logic                        busy,
	input logic [POS_WIDTH-1:0]        position,
	input logic [COUNT_WIDTH-1:0]      male_a,
	input logic [COUNT_WIDTH-1:0]      male_t,
	input logic [COUNT_WIDTH-1:0]      male_g,
	input logic [COUNT_WIDTH-1:0]      male_c,
	input logic [COUNT_WIDTH-1:0]      male_indel,
	input logic [COUNT_WIDTH-1:0]      female_a,
	input logic [COUNT_WIDTH-1:0]      female_t,
	input logic [COUNT_WIDTH-1:0]      female_g,
	input logic [COUNT_WIDTH-1:0]      female_c,
	input logic [COUNT_WIDTH-1:0]      female_indel,
	input logic                        done,
	input logic [POS_WIDTH-1:0]        out_position,
	input logic signed [FST_WIDTH-1:0] fst_value,
	input logic                        fst_report,
	input logic [1:0]                  snp_class
);

	logic [TOT_WIDTH-1:0] tot_m;
	logic [TOT_WIDTH-1:0] tot_f;

	assign tot_m = TOT_WIDTH'(male_a) + TOT_WIDTH'(male_t) + TOT_WIDTH'(male_g) +
		TOT_WIDTH'(male_c) + TOT_WIDTH'(male_indel);
	assign tot_f = TOT_WIDTH'(female_a) + TOT_WIDTH'(female_t) + TOT_WIDTH'(female_g) +
		TOT_WIDTH'(female_c) + TOT_WIDTH'(female_indel);

	// every result stems from an accepted transaction, offset by the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without matching transaction");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_position == $past(position, PIPE_DEPTH))
		else $error("position not carried through");

	a_low_cov: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(tot_m, PIPE_DEPTH) < TOT_WIDTH'(2) ||
			$past(tot_f, PIPE_DEPTH) < TOT_WIDTH'(2))
		|-> fst_value == '0 && snp_class == 2'b00)
		else $error("low coverage position not cleared");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (fst_value <= $signed(FST_WIDTH'(P_ONE)) &&
			fst_value >= -$signed(FST_WIDTH'(P_ONE))))
		else $error("fst outside saturation range");

endmodule

bind sex_fst_snp_classifier sfsc_checker u_sfsc_checker (.*);
